// ----- design/ewse_pkg.sv -----
package ewse_pkg;

    // channel field is one bit wide, so two channels are addressable
    localparam int CHANNELS       = 2;
    localparam int CH_W           = 1;
    localparam int COUNT_W        = 16;
    localparam int SPAN_W         = 17;
    localparam int SPEED_W        = 16;
    localparam int RPM_W          = 18;
    localparam int DIFF_W         = 19;
    localparam int WINDOW_DEFAULT = 8;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 17'd65535;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

endpackage

// ----- design/encoder_window_speed_estimator.sv -----
// windowed-difference speed estimator for two quadrature encoder channels
//
// input channel: i_valid / o_stall, payload i_channel, i_count. a transaction
// is taken at a rising edge with i_valid high and o_stall low. one sample per
// cycle is sustained while i_stall is low; the only shared resource is the sample
// ring memory, read once per sample and written once per non-priming sample.
// output channel: o_valid / i_stall, payload o_out_channel, o_speed_counts,
// o_speed_rpm_sixteenths. every input transaction gives exactly one output
// transaction, by way of the ring read stage and then the result register.
// throughput is one transaction per cycle while the receiver does not stall.
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_data (wrap span); the
// port is always ready. write it only while the block is idle.
// when the receiver stalls, the result register holds and the ring read
// stage fills; o_stall then rises until the result is taken. nothing is lost.
// reset (synchronous, i_rst_n low) clears all channels to unprimed, ring
// pointers to zero and the wrap span to 65535. the ring needs no clearing:
// until a channel's pointer wraps, reads return its priming sample instead.
module encoder_window_speed_estimator
    import ewse_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [CH_W-1:0]           i_channel,
    input  logic [COUNT_W-1:0]        i_count,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [CH_W-1:0]           o_out_channel,
    output logic signed [SPEED_W-1:0] o_speed_counts,
    output logic signed [RPM_W-1:0]   o_speed_rpm_sixteenths,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [SPAN_W-1:0]         i_cfg_data
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    // configuration
    logic [SPAN_W-1:0] r_wrap_span;

    // per channel bookkeeping
    logic [CHANNELS-1:0] r_primed;
    logic [CHANNELS-1:0] r_wrapped;        // pointer has gone round once since priming
    logic [PTR_W-1:0]    r_ptr   [CHANNELS];
    logic [COUNT_W-1:0]  r_prime [CHANNELS];

    // sample ring
    logic [COUNT_W-1:0]  r_ring  [CHANNELS][WINDOW];

    // ring read stage
    logic                r_a_valid;
    logic [CH_W-1:0]     r_a_channel;
    logic [COUNT_W-1:0]  r_a_count;
    logic                r_a_is_prime;     // priming sample, no difference taken
    logic                r_a_use_prime;    // oldest entry still holds the priming value
    logic [COUNT_W-1:0]  r_a_prime_val;
    logic [PTR_W-1:0]    r_a_ptr;
    logic [COUNT_W-1:0]  r_rd_data;

    // result register
    logic                       r_o_valid;
    logic [CH_W-1:0]            r_o_channel;
    logic signed [SPEED_W-1:0]  r_o_speed;

    logic accept;
    logic advance;
    logic ring_we;
    logic [COUNT_W-1:0] oldest;
    logic signed [DIFF_W-1:0] n_raw;
    logic signed [DIFF_W-1:0] n_corr;
    logic signed [DIFF_W-1:0] half_s;
    logic signed [DIFF_W-1:0] span_s;
    logic signed [SPEED_W-1:0] n_speed;

    // result stage moves when empty or taken
    assign advance = !r_o_valid || !i_stall;
    assign o_stall = r_a_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign ring_we = advance && r_a_valid && !r_a_is_prime;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_span <= SPAN_RESET;
        end else if (i_cfg_valid) begin
            r_wrap_span <= i_cfg_data;
        end
    end

    // channel bookkeeping is done at acceptance, it needs no sample data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed  <= '0;
            r_wrapped <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c] <= '0;
            end
        end else if (accept) begin
            if (!r_primed[i_channel]) begin
                r_primed[i_channel] <= 1'b1;
            end else begin
                if (r_ptr[i_channel] == PTR_LAST) begin
                    r_ptr[i_channel]     <= '0;
                    r_wrapped[i_channel] <= 1'b1;
                end else begin
                    r_ptr[i_channel] <= r_ptr[i_channel] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_primed[i_channel]) begin
            r_prime[i_channel] <= i_count;
        end
    end

    // ring memory: one write from the compute stage, one registered read
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_a_channel][r_a_ptr] <= r_a_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (ring_we && r_a_channel == i_channel && r_a_ptr == r_ptr[i_channel]) begin
                r_rd_data <= r_a_count;
            end else begin
                r_rd_data <= r_ring[i_channel][r_ptr[i_channel]];
            end
        end
    end

    // ring read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_channel   <= i_channel;
            r_a_count     <= i_count;
            r_a_is_prime  <= !r_primed[i_channel];
            r_a_use_prime <= !r_wrapped[i_channel];
            r_a_prime_val <= r_prime[i_channel];
            r_a_ptr       <= r_ptr[i_channel];
        end
    end

    // wrap-corrected difference, saturated to 16 bits
    always_comb begin
        oldest = r_a_use_prime ? r_a_prime_val : r_rd_data;
        n_raw  = $signed({3'b000, r_a_count}) - $signed({3'b000, oldest});
        half_s = $signed({3'b000, r_wrap_span[SPAN_W-1:1]});
        span_s = $signed({2'b00, r_wrap_span});
        if (n_raw > half_s) begin
            n_corr = n_raw - span_s;
        end else if (n_raw < -half_s) begin
            n_corr = n_raw + span_s;
        end else begin
            n_corr = n_raw;
        end
        if (r_a_is_prime) begin
            n_speed = '0;
        end else if (n_corr > DIFF_W'(SPEED_MAX)) begin
            n_speed = SPEED_MAX;
        end else if (n_corr < DIFF_W'(SPEED_MIN)) begin
            n_speed = SPEED_MIN;
        end else begin
            n_speed = n_corr[SPEED_W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_a_valid) begin
            r_o_channel <= r_a_channel;
            r_o_speed   <= n_speed;
        end
    end

    assign o_valid                = r_o_valid;
    assign o_out_channel          = r_o_channel;
    assign o_speed_counts         = r_o_speed;
    // speed * 3 gives rpm in sixteenths
    assign o_speed_rpm_sixteenths = (RPM_W'(r_o_speed) <<< 1) + RPM_W'(r_o_speed);

    // stall only ever backs up behind an occupied read stage
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> !o_stall)
        else $error("input stalled with empty read stage");

    // an item in the read stage reaches the result register when it moves
    a_item_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && advance) |=> o_valid)
        else $error("item lost between read stage and result register");

    // a channel can only wrap after it has been primed
    a_wrap_after_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wrapped & ~r_primed) == '0)
        else $error("ring wrapped on an unprimed channel");

    // a held result stays put while stalled
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_o_speed) && $stable(r_o_channel))
        else $error("stalled result changed");

endmodule
